// ===== rtl/core/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
package deq_pkg;

    // Storage shape of the queue.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int COUNT_W    = $clog2(DEPTH + 1);

    // Fixed widths of the stream fields.
    localparam int VALUE_W  = 32;
    localparam int EXT_CNT_W = 5;

    // Operation codes carried by an input transaction.
    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

    // Status codes reported with every result.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                  clear;
        logic                  add_front;
        logic                  take_front;
        logic                  add_back;
        logic                  take_back;
        logic [DATA_WIDTH-1:0] data;
    } deq_cmd_t;

    // Contents of one cell as seen by its neighbors.
    typedef struct packed {
        logic                  valid;
        logic [DATA_WIDTH-1:0] data;
    } deq_link_t;

endpackage

// ===== rtl/core/double_ended_queue.sv =====
// Top level of the double-ended queue built as a chain of storage cells.
//
// Usage: each input transaction on s_tdata carries an operation (push back,
// push front, pop front, pop back, clear) and a value. Every accepted
// transaction produces exactly one result transaction on m_tdata with the
// front and rear values, the entry count, empty and full flags and a status.
// Pops on an empty queue report underflow, pushes on a full queue report
// overflow, and neither changes the contents.
// The result is registered and presented in the cycle after the input
// transaction is accepted. One transaction per cycle while the receiver takes results;
// the cells all shift or load in the same cycle, so the per-cell update sets the rate.
// The result sits in an output register. While it waits, the block still
// accepts a new transaction in the cycle the receiver takes the old one, so
// s_tready follows m_tready when a result is pending.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result. No clearing pass is needed: every cell has its own valid flag.
module double_ended_queue import deq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] operation, [34:3] value, [39:35] zero
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] front_value, [63:32] rear_value, [68:64] entry_count,
    // [69] is_empty, [70] is_full, [72:71] status, [79:73] zero
    output logic [79:0] m_tdata
);

    logic                  s_accept;
    op_t                   op;
    logic [VALUE_W-1:0]    in_value;
    logic                  q_full;
    logic                  q_empty;
    deq_cmd_t              cmd;
    status_t               status_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;

    deq_link_t             cell_state [DEPTH];
    deq_link_t             cell_nxt   [DEPTH];
    logic [DEPTH-1:0]      valid_now;
    logic [DEPTH-1:0]      valid_nxt;
    logic [DEPTH-1:0]      rear_sel;
    logic [DATA_WIDTH-1:0] front_nxt;
    logic [DATA_WIDTH-1:0] rear_nxt;

    logic                  m_valid_reg;
    logic [VALUE_W-1:0]    front_reg;
    logic [VALUE_W-1:0]    rear_reg;
    logic [EXT_CNT_W-1:0]  count_out_reg;
    logic                  empty_reg;
    logic                  full_reg;
    status_t               status_reg;

    // Input handshake: take a transaction whenever the result slot frees up.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign op       = op_t'(s_tdata[2:0]);
    assign in_value = s_tdata[34:3];

    assign q_full  = cell_state[DEPTH-1].valid;
    assign q_empty = !cell_state[0].valid;

    // Decode the operation into a cell command, count update and status.
    always_comb begin
        cmd         = '0;
        cmd.data    = DATA_WIDTH'(in_value);
        status_next = ST_OK;
        count_next  = count_reg;
        if (s_accept) begin
            case (op)
                OP_PUSH_BACK: begin
                    if (q_full) begin
                        status_next = ST_OVERFLOW;
                    end else begin
                        cmd.add_back = 1'b1;
                        count_next   = count_reg + 1'b1;
                    end
                end
                OP_PUSH_FRONT: begin
                    if (q_full) begin
                        status_next = ST_OVERFLOW;
                    end else begin
                        cmd.add_front = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (q_empty) begin
                        status_next = ST_UNDERFLOW;
                    end else begin
                        cmd.take_front = 1'b1;
                        count_next     = count_reg - 1'b1;
                    end
                end
                OP_POP_BACK: begin
                    if (q_empty) begin
                        status_next = ST_UNDERFLOW;
                    end else begin
                        cmd.take_back = 1'b1;
                        count_next    = count_reg - 1'b1;
                    end
                end
                OP_CLEAR: begin
                    cmd.clear  = 1'b1;
                    count_next = '0;
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // The chain of cells; the front cell sees the pushed value on its left.
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            deq_link_t left_link;
            deq_link_t right_link;
            if (i == 0) begin : g_first
                assign left_link = '{valid: 1'b1, data: cmd.data};
            end else begin : g_inner_l
                assign left_link = cell_state[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign right_link = '{valid: 1'b0, data: '0};
            end else begin : g_inner_r
                assign right_link = cell_state[i+1];
            end
            deq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .left_in    (left_link),
                .right_in   (right_link),
                .state_out  (cell_state[i]),
                .state_next (cell_nxt[i])
            );
            assign valid_now[i] = cell_state[i].valid;
            assign valid_nxt[i] = cell_nxt[i].valid;
        end
    endgenerate

    // Front and rear of the updated queue; the rear is the last held cell.
    assign rear_sel  = valid_nxt & ~(valid_nxt >> 1);
    assign front_nxt = valid_nxt[0] ? cell_nxt[0].data : '0;

    always_comb begin
        rear_nxt = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rear_nxt = rear_nxt | (cell_nxt[k].data & {DATA_WIDTH{rear_sel[k]}});
        end
    end

    // Entry count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Result output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            front_reg     <= VALUE_W'(front_nxt);
            rear_reg      <= VALUE_W'(rear_nxt);
            count_out_reg <= EXT_CNT_W'(count_next);
            empty_reg     <= !valid_nxt[0];
            full_reg      <= valid_nxt[DEPTH-1];
            status_reg    <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, status_reg, full_reg, empty_reg, count_out_reg,
                       rear_reg, front_reg};

    // The count register always matches the number of held cells.
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_now) == 32'(count_reg))
        else $error("entry count differs from held cells");

    // Held cells form one unbroken run from the front.
    a_valid_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_now >> 1) & ~valid_now) == '0)
        else $error("hole in the cell chain");

    // An underflow result always reports an empty queue.
    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == ST_UNDERFLOW) |-> (empty_reg && count_out_reg == '0))
        else $error("underflow reported on a non-empty queue");

    // An overflow result always reports a full queue.
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == ST_OVERFLOW) |-> full_reg)
        else $error("overflow reported on a queue that is not full");

    // A pending result that is not taken keeps the block from accepting.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while a result is stalled");

endmodule

// ===== rtl/core/deq_cell.sv =====
// One storage cell of the queue chain; cell i holds the entry i places from the front.
module deq_cell import deq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  deq_cmd_t  cmd,
    input  deq_link_t left_in,
    input  deq_link_t right_in,
    output deq_link_t state_out,
    output deq_link_t state_next
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // Next contents: shift from a neighbor, take the pushed value, or drop out.
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (cmd.clear) begin
            valid_next = 1'b0;
        end else if (cmd.add_front) begin
            valid_next = left_in.valid;
            data_next  = left_in.data;
        end else if (cmd.take_front) begin
            valid_next = right_in.valid;
            data_next  = right_in.data;
        end else if (cmd.add_back) begin
            // The first empty cell behind a full one takes the new rear entry.
            if (!valid_reg && left_in.valid) begin
                valid_next = 1'b1;
                data_next  = cmd.data;
            end
        end else if (cmd.take_back) begin
            // The last held cell lets its entry go.
            if (valid_reg && !right_in.valid) begin
                valid_next = 1'b0;
            end
        end
    end

    // The valid flag is control state; the data needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign state_out  = '{valid: valid_reg, data: data_reg};
    assign state_next = '{valid: valid_next, data: data_next};

endmodule

// ===== test/tb_double_ended_queue.sv =====
// Self-checking testbench for the double-ended queue with a built-in deque predictor.
module tb_double_ended_queue import deq_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes that the block must treat as no-ops.
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    // Receiver hold-off length and the quiet-cycle limit of the watchdog.
    localparam int HOLD_CYCLES   = 80;
    localparam int QUIET_LIMIT   = 2000;
    localparam int MAX_PRINTED   = 30;
    localparam int RANDOM_ITEMS  = 400;

    // Front/rear snapshot that one result transaction carries.
    typedef struct {
        logic [VALUE_W-1:0]   front;
        logic [VALUE_W-1:0]   rear;
        logic [EXT_CNT_W-1:0] count;
        logic                 empty;
        logic                 full;
        status_t              status;
    } deque_view_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [2:0] operation, [34:3] value, [39:35] zero
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [31:0] front_value, [63:32] rear_value, [68:64] entry_count,
    // [69] is_empty, [70] is_full, [72:71] status, [79:73] zero
    logic [79:0] m_tdata;

    // Predictor state: a ring of entries, the front position and the fill level.
    logic [DATA_WIDTH-1:0] ring_entries [DEPTH];
    int                    ring_head  = 0;
    int                    ring_count = 0;

    deque_view_t expected_views [$];

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int hold_grants   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int results_seen  = 0;
    int error_count   = 0;

    double_ended_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Prints one mismatch line (up to a cap) and counts it.
    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_seen, name, got, want));
        end
    endtask

    // Applies one operation to the predictor and returns the view that follows it.
    function automatic deque_view_t deque_apply(input logic [2:0] code,
                                                input logic [31:0] val);
        deque_view_t v;
        v.status = ST_OK;
        case (code)
            OP_PUSH_BACK: begin
                if (ring_count == DEPTH) begin
                    v.status = ST_OVERFLOW;
                end else begin
                    ring_entries[(ring_head + ring_count) % DEPTH] = val[DATA_WIDTH-1:0];
                    ring_count++;
                end
            end
            OP_PUSH_FRONT: begin
                if (ring_count == DEPTH) begin
                    v.status = ST_OVERFLOW;
                end else begin
                    ring_head = (ring_head + DEPTH - 1) % DEPTH;
                    ring_entries[ring_head] = val[DATA_WIDTH-1:0];
                    ring_count++;
                end
            end
            OP_POP_FRONT: begin
                if (ring_count == 0) begin
                    v.status = ST_UNDERFLOW;
                end else begin
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_count--;
                end
            end
            OP_POP_BACK: begin
                if (ring_count == 0) begin
                    v.status = ST_UNDERFLOW;
                end else begin
                    ring_count--;
                end
            end
            OP_CLEAR: begin
                ring_head  = 0;
                ring_count = 0;
            end
            default: ;
        endcase
        // An empty queue shows zero at both ends.
        v.front = '0;
        v.rear  = '0;
        if (ring_count > 0) begin
            v.front = VALUE_W'(ring_entries[ring_head]);
            v.rear  = VALUE_W'(ring_entries[(ring_head + ring_count - 1) % DEPTH]);
        end
        v.count = EXT_CNT_W'(ring_count);
        v.empty = (ring_count == 0);
        v.full  = (ring_count == DEPTH);
        return v;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Offers one transaction after a random gap and records its expected result.
    task automatic send_op(input logic [2:0] code, input logic [31:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, val, code};
        do @(posedge aclk); while (!s_tready);
        expected_views.push_back(deque_apply(code, val));
    endtask

    // Stops offering and waits until every expected result has arrived.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_views.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != hold_grants) begin
            hold_grants <= hold_requests;
            hold_left   <= HOLD_CYCLES - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Result checker and watchdog.
    always @(posedge aclk) begin : result_check
        deque_view_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_views.size() == 0) begin
                report_mismatch("result transaction with no expectation pending");
            end else begin
                want = expected_views.pop_front();
                check_field("front_value", m_tdata[31:0],  want.front);
                check_field("rear_value",  m_tdata[63:32], want.rear);
                check_field("entry_count", 32'(m_tdata[68:64]), 32'(want.count));
                check_field("is_empty",    32'(m_tdata[69]),    32'(want.empty));
                check_field("is_full",     32'(m_tdata[70]),    32'(want.full));
                check_field("status",      32'(m_tdata[72:71]), 32'(want.status));
            end
            results_seen++;
        end
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Pops on an empty queue report underflow; clear on an empty queue is harmless.
    task automatic test_empty_pops();
        send_op(OP_POP_FRONT, random_value());
        send_op(OP_POP_BACK, random_value());
        send_op(OP_CLEAR, random_value());
        wait_for_results();
    endtask

    // A lone entry is both front and rear, whichever end it enters and leaves by.
    task automatic test_single_entry();
        send_op(OP_PUSH_FRONT, random_value());
        send_op(OP_POP_BACK, random_value());
        send_op(OP_PUSH_BACK, random_value());
        send_op(OP_POP_FRONT, random_value());
        send_op(OP_PUSH_FRONT, random_value());
        send_op(OP_POP_FRONT, random_value());
        wait_for_results();
    endtask

    // All-zero and all-one values at both ends, then a clear with entries held.
    task automatic test_extreme_values();
        send_op(OP_PUSH_BACK, '0);
        send_op(OP_PUSH_FRONT, '1);
        send_op(OP_PUSH_BACK, '1);
        send_op(OP_PUSH_FRONT, '0);
        send_op(OP_POP_FRONT, '1);
        send_op(OP_POP_BACK, '1);
        send_op(OP_CLEAR, '1);
        wait_for_results();
    endtask

    // Unused operation codes leave the contents alone.
    task automatic test_unused_codes();
        logic [2:0] code;
        send_op(OP_PUSH_BACK, random_value());
        for (code = OP_UNUSED_LO; code != OP_UNUSED_HI; code++) begin
            send_op(code, random_value());
        end
        send_op(OP_UNUSED_HI, random_value());
        send_op(OP_POP_FRONT, random_value());
        wait_for_results();
    endtask

    // The receiver holds off while pushes keep coming, so the input stalls;
    // the queue fills, overflows at both ends, and is cleared while full.
    task automatic test_fill_under_backpressure();
        int i;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_op(OP_CLEAR, random_value());
        hold_requests <= hold_requests + 1;
        for (i = 0; i < DEPTH + 2; i++) begin
            send_op((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, random_value());
        end
        send_op(OP_CLEAR, random_value());
        wait_for_results();
    endtask

    // Bursts leaning toward pushes or pops so that the fill level sweeps
    // between empty and full, with clears and unused codes mixed in.
    task automatic test_random_traffic(input int n_items, input int tx_pct,
                                       input int rx_pct);
        int         sent;
        int         burst;
        int         push_pct;
        int         pick;
        logic [2:0] code;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(24, 1);
            case ($urandom_range(2))
                0:       push_pct = 80;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            repeat (burst) begin
                pick = $urandom_range(99);
                if (pick < 2) begin
                    code = OP_CLEAR;
                end else if (pick < 5) begin
                    code = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
                end else if ($urandom_range(99) < push_pct) begin
                    code = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                end else begin
                    code = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
                end
                send_op(code, random_value());
                sent++;
            end
        end
        wait_for_results();
    endtask

    // Test sequence.
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 18;
        rx_idle_pct = 63;
        test_empty_pops();
        test_single_entry();
        test_extreme_values();
        test_unused_codes();
        test_fill_under_backpressure();

        test_random_traffic(RANDOM_ITEMS / 3, 18, 63);
        test_random_traffic(RANDOM_ITEMS / 3, 63, 18);
        test_random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0);

        // Let any stray result show up before the verdict.
        repeat (4) @(posedge aclk);
        if (expected_views.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_views.size()));
        end
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
